### rtl/biquad_iir_filter_q14_core_assert.svh
// Assertion macros used by the step sequencer of the biquad filter RTL.
`ifndef BIQUAD_IIR_FILTER_Q14_CORE_ASSERT_SVH
`define BIQUAD_IIR_FILTER_Q14_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("biquad core: assertion failed");

// Next-cycle implication.
`define BQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("biquad core: assertion failed");

`endif

### rtl/bq_pkg.sv
// Shared constants, types and control structs of the biquad filter core.
package bq_pkg;

    localparam int COEF_FRAC_BITS = 14;
    localparam int SAMPLE_W       = 32;
    localparam int COEF_W         = 16;
    localparam int Q_W            = SAMPLE_W + COEF_FRAC_BITS;
    localparam int MUL_A_W        = SAMPLE_W + 1;
    localparam int PROD_W         = MUL_A_W + COEF_W;
    localparam int ACC_W          = SAMPLE_W + COEF_W + 3;
    localparam int STEP_W         = 4;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_DF1_MODE = CFG_IDX_W'(5);

    localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 16'sd16384;

    localparam logic [STEP_W-1:0] LAST_STEP_INT = STEP_W'(7);
    localparam logic [STEP_W-1:0] LAST_STEP_DF1 = STEP_W'(8);

    localparam longint S32_MAX_L = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint S32_MIN_L = -(longint'(1) << (SAMPLE_W - 1));
    localparam longint Q_ONE_L   = longint'(1) << COEF_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ACC_S32_MAX = ACC_W'(S32_MAX_L);
    localparam logic signed [ACC_W-1:0] ACC_S32_MIN = ACC_W'(S32_MIN_L);
    localparam logic signed [ACC_W-1:0] ACC_Q_MAX   = ACC_W'(S32_MAX_L * Q_ONE_L);
    localparam logic signed [ACC_W-1:0] ACC_Q_MIN   = ACC_W'(S32_MIN_L * Q_ONE_L);
    localparam logic signed [ACC_W-1:0] ACC_RND     =
        ACC_W'(longint'(1) << (COEF_FRAC_BITS - 1));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        MS_X_B0,
        MS_X_B1,
        MS_X_B2,
        MS_X1_B1,
        MS_X2_B2,
        MS_HI1_A1,
        MS_LO1_A1,
        MS_HI2_A2,
        MS_LO2_A2,
        MS_Y_A1,
        MS_Y_A2
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_FIRST,
        BASE_SECOND
    } t_base_sel;

    typedef struct packed {
        t_acc_op acc_op;
        logic    prod_shift;
    } t_mac_ctl;

    typedef struct packed {
        t_mac_ctl  mac;
        t_mul_sel  mul_sel;
        t_base_sel base_sel;
        logic      cap_y;
        logic      store_first;
        logic      store_second;
        logic      df1_update;
        logic      last;
        logic      out_load;
        logic      out_held;
    } t_ctl;

endpackage

### rtl/bq_mac.sv
// Shared multiplier with product register and accumulator.
module bq_mac (
    input  logic                              i_clk,
    input  logic signed [bq_pkg::MUL_A_W-1:0] i_mul_a,
    input  logic signed [bq_pkg::COEF_W-1:0]  i_mul_b,
    input  logic signed [bq_pkg::ACC_W-1:0]   i_base,
    input  bq_pkg::t_mac_ctl                  i_ctl,
    output logic signed [bq_pkg::ACC_W-1:0]   o_acc
);
    import bq_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  r_acc;

    // arithmetic shift gives floor of the Q product
    assign prod_sh = i_ctl.prod_shift ? (r_prod >>> COEF_FRAC_BITS) : r_prod;
    assign addend  = {{(ACC_W - PROD_W){prod_sh[PROD_W-1]}}, prod_sh};

    always_ff @(posedge i_clk) begin
        r_prod <= i_mul_a * i_mul_b;
        case (i_ctl.acc_op)
            ACC_LOAD: r_acc <= i_base + addend;
            ACC_ADD:  r_acc <= r_acc + addend;
            default:  r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

### rtl/bq_ctrl.sv
// Step sequencer of the biquad core: issues one product per cycle while running.
`include "biquad_iir_filter_q14_core_assert.svh"

module bq_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_df1,
    input  logic         i_out_free,
    output logic         o_ready,
    output bq_pkg::t_ctl o_ctl
);
    import bq_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctl              ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_step           = r_step;
        ctl.mac.acc_op   = ACC_HOLD;
        ctl.mac.prod_shift = 1'b0;
        ctl.mul_sel      = MS_X_B0;
        ctl.base_sel     = BASE_ZERO;
        ctl.cap_y        = 1'b0;
        ctl.store_first  = 1'b0;
        ctl.store_second = 1'b0;
        ctl.df1_update   = 1'b0;
        ctl.last         = 1'b0;
        ctl.out_load     = 1'b0;
        ctl.out_held     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                n_step = r_step + STEP_W'(1);
                if (!i_df1) begin
                    // transposed form: y first, then both accumulators
                    case (r_step)
                        STEP_W'(0): ctl.mul_sel = MS_X_B0;
                        STEP_W'(1): begin
                            ctl.mac.acc_op = ACC_LOAD;
                            ctl.base_sel   = BASE_FIRST;
                            ctl.mul_sel    = MS_X_B1;
                        end
                        STEP_W'(2): begin
                            ctl.cap_y      = 1'b1;
                            ctl.mac.acc_op = ACC_LOAD;
                            ctl.base_sel   = BASE_SECOND;
                        end
                        STEP_W'(3): ctl.mul_sel = MS_Y_A1;
                        STEP_W'(4): begin
                            ctl.mac.acc_op = ACC_ADD;
                            ctl.mul_sel    = MS_X_B2;
                        end
                        STEP_W'(5): begin
                            ctl.store_first = 1'b1;
                            ctl.mac.acc_op  = ACC_LOAD;
                            ctl.base_sel    = BASE_ZERO;
                            ctl.mul_sel     = MS_Y_A2;
                        end
                        STEP_W'(6): ctl.mac.acc_op = ACC_ADD;
                        default: begin
                            ctl.store_second = 1'b1;
                            ctl.last         = 1'b1;
                        end
                    endcase
                end else begin
                    // form I: seven products summed, feedback split in hi/lo halves
                    case (r_step)
                        STEP_W'(0): ctl.mul_sel = MS_X_B0;
                        STEP_W'(1): begin
                            ctl.mac.acc_op = ACC_LOAD;
                            ctl.base_sel   = BASE_ZERO;
                            ctl.mul_sel    = MS_X1_B1;
                        end
                        STEP_W'(2): begin
                            ctl.mac.acc_op = ACC_ADD;
                            ctl.mul_sel    = MS_X2_B2;
                        end
                        STEP_W'(3): begin
                            ctl.mac.acc_op = ACC_ADD;
                            ctl.mul_sel    = MS_HI1_A1;
                        end
                        STEP_W'(4): begin
                            ctl.mac.acc_op = ACC_ADD;
                            ctl.mul_sel    = MS_LO1_A1;
                        end
                        STEP_W'(5): begin
                            ctl.mac.acc_op     = ACC_ADD;
                            ctl.mac.prod_shift = 1'b1;
                            ctl.mul_sel        = MS_HI2_A2;
                        end
                        STEP_W'(6): begin
                            ctl.mac.acc_op = ACC_ADD;
                            ctl.mul_sel    = MS_LO2_A2;
                        end
                        STEP_W'(7): begin
                            ctl.mac.acc_op     = ACC_ADD;
                            ctl.mac.prod_shift = 1'b1;
                        end
                        default: begin
                            ctl.df1_update = 1'b1;
                            ctl.last       = 1'b1;
                        end
                    endcase
                end
                if (ctl.last) begin
                    n_step = '0;
                    if (i_out_free) begin
                        ctl.out_load = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    ctl.out_load = 1'b1;
                    ctl.out_held = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_ctl   = ctl;

    `BQ_ASSERT_IMP(a_idle_step_zero, i_clk, i_rst_n, r_state == ST_IDLE, r_step == '0)
    `BQ_ASSERT_NXT(a_start_runs, i_clk, i_rst_n, i_start, r_state == ST_RUN && r_step == '0)
    `BQ_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, ctl.out_load, i_out_free)
    `BQ_ASSERT_IMP(a_step_bound, i_clk, i_rst_n, r_state == ST_RUN, r_step <= LAST_STEP_DF1)
    `BQ_ASSERT_IMP(a_int_last, i_clk, i_rst_n, ctl.last && !i_df1, r_step == LAST_STEP_INT)

endmodule

### rtl/biquad_iir_filter_q14_core.sv
// Biquad IIR core with a transposed mode and a form I mode.
// One item at a time; the next item is taken the cycle after the result is registered,
// so a new item is never accepted while the previous one is still being filtered.
// All products go through the single shared 33x16 multiplier, one product per cycle.
// The output register holds a result while the next item is already being filtered.
// Synchronous active-low reset restores the coefficients and clears all filter state.
module biquad_iir_filter_q14_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bq_pkg::SAMPLE_W-1:0]       s_axis_tdata,  // [31:0] sample
    input  logic                              s_axis_tuser,  // [0] restart
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bq_pkg::SAMPLE_W-1:0]       m_axis_tdata,  // [31:0] filtered sample
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bq_pkg::COEF_W-1:0]         i_cfg_data
);
    import bq_pkg::*;

    logic signed [COEF_W-1:0]   r_coef_b0, r_coef_b1, r_coef_b2, r_coef_a1, r_coef_a2;
    logic                       r_df1;
    logic signed [ACC_W-1:0]    r_acc_first, r_acc_second;
    logic signed [SAMPLE_W-1:0] r_prev_in_one, r_prev_in_two;
    logic signed [Q_W-1:0]      r_prev_out_one, r_prev_out_two;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_y;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_data;

    logic                       ready;
    logic                       accept;
    logic                       out_free;
    t_ctl                       ctl;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [COEF_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]    base;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    int_sh;
    logic signed [SAMPLE_W-1:0] int_y;
    logic signed [ACC_W-1:0]    v_cl;
    logic signed [ACC_W-1:0]    v_q;
    logic                       neg_frac;
    logic signed [SAMPLE_W-1:0] df1_y;
    logic signed [SAMPLE_W-1:0] y_live;

    assign accept        = s_axis_tvalid && ready;
    assign s_axis_tready = ready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0 <= COEF_B0_RESET;
            r_coef_b1 <= '0;
            r_coef_b2 <= '0;
            r_coef_a1 <= '0;
            r_coef_a2 <= '0;
            r_df1     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COEF_B0:  r_coef_b0 <= i_cfg_data;
                CFG_COEF_B1:  r_coef_b1 <= i_cfg_data;
                CFG_COEF_B2:  r_coef_b2 <= i_cfg_data;
                CFG_COEF_A1:  r_coef_a1 <= i_cfg_data;
                CFG_COEF_A2:  r_coef_a2 <= i_cfg_data;
                CFG_DF1_MODE: r_df1     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_df1      (r_df1),
        .i_out_free (out_free),
        .o_ready    (ready),
        .o_ctl      (ctl)
    );

    // multiplier operands; stored outputs split into signed high and unsigned low part
    always_comb begin
        case (ctl.mul_sel)
            MS_X_B0:   begin mul_a = {r_x[SAMPLE_W-1], r_x};         mul_b = r_coef_b0; end
            MS_X_B1:   begin mul_a = {r_x[SAMPLE_W-1], r_x};         mul_b = r_coef_b1; end
            MS_X_B2:   begin mul_a = {r_x[SAMPLE_W-1], r_x};         mul_b = r_coef_b2; end
            MS_X1_B1: begin
                mul_a = {r_prev_in_one[SAMPLE_W-1], r_prev_in_one};
                mul_b = r_coef_b1;
            end
            MS_X2_B2: begin
                mul_a = {r_prev_in_two[SAMPLE_W-1], r_prev_in_two};
                mul_b = r_coef_b2;
            end
            MS_HI1_A1: begin
                mul_a = {r_prev_out_one[Q_W-1], r_prev_out_one[Q_W-1:COEF_FRAC_BITS]};
                mul_b = r_coef_a1;
            end
            MS_LO1_A1: begin
                mul_a = {{(MUL_A_W - COEF_FRAC_BITS){1'b0}},
                         r_prev_out_one[COEF_FRAC_BITS-1:0]};
                mul_b = r_coef_a1;
            end
            MS_HI2_A2: begin
                mul_a = {r_prev_out_two[Q_W-1], r_prev_out_two[Q_W-1:COEF_FRAC_BITS]};
                mul_b = r_coef_a2;
            end
            MS_LO2_A2: begin
                mul_a = {{(MUL_A_W - COEF_FRAC_BITS){1'b0}},
                         r_prev_out_two[COEF_FRAC_BITS-1:0]};
                mul_b = r_coef_a2;
            end
            MS_Y_A1:   begin mul_a = {r_y[SAMPLE_W-1], r_y};         mul_b = r_coef_a1; end
            MS_Y_A2:   begin mul_a = {r_y[SAMPLE_W-1], r_y};         mul_b = r_coef_a2; end
            default:   begin mul_a = {r_x[SAMPLE_W-1], r_x};         mul_b = r_coef_b0; end
        endcase
    end

    always_comb begin
        case (ctl.base_sel)
            BASE_FIRST:  base = r_acc_first + ACC_RND;
            BASE_SECOND: base = r_acc_second;
            default:     base = '0;
        endcase
    end

    bq_mac u_mac (
        .i_clk   (i_clk),
        .i_mul_a (mul_a),
        .i_mul_b (mul_b),
        .i_base  (base),
        .i_ctl   (ctl.mac),
        .o_acc   (acc)
    );

    // transposed form: floor shift then saturate
    assign int_sh = acc >>> COEF_FRAC_BITS;
    always_comb begin
        if (int_sh > ACC_S32_MAX) begin
            int_y = ACC_S32_MAX[SAMPLE_W-1:0];
        end else if (int_sh < ACC_S32_MIN) begin
            int_y = ACC_S32_MIN[SAMPLE_W-1:0];
        end else begin
            int_y = int_sh[SAMPLE_W-1:0];
        end
    end

    // form I: clamp in Q format, then divide truncating toward zero
    always_comb begin
        if (acc > ACC_Q_MAX) begin
            v_cl = ACC_Q_MAX;
        end else if (acc < ACC_Q_MIN) begin
            v_cl = ACC_Q_MIN;
        end else begin
            v_cl = acc;
        end
    end
    assign v_q      = v_cl >>> COEF_FRAC_BITS;
    assign neg_frac = v_cl[ACC_W-1] && (|v_cl[COEF_FRAC_BITS-1:0]);
    assign df1_y    = v_q[SAMPLE_W-1:0] + {{(SAMPLE_W - 1){1'b0}}, neg_frac};

    assign y_live = (r_df1 && !ctl.out_held) ? df1_y : r_y;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= s_axis_tdata;
        end
        if (ctl.cap_y) begin
            r_y <= int_y;
        end else if (ctl.last) begin
            r_y <= y_live;
        end
    end

    // filter state, cleared by reset and by the restart flag of an item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && s_axis_tuser)) begin
            r_acc_first    <= '0;
            r_acc_second   <= '0;
            r_prev_in_one  <= '0;
            r_prev_in_two  <= '0;
            r_prev_out_one <= '0;
            r_prev_out_two <= '0;
        end else begin
            if (ctl.store_first) begin
                r_acc_first <= acc;
            end
            if (ctl.store_second) begin
                r_acc_second <= acc;
            end
            if (ctl.df1_update) begin
                r_prev_in_two  <= r_prev_in_one;
                r_prev_in_one  <= r_x;
                r_prev_out_two <= r_prev_out_one;
                r_prev_out_one <= v_cl[Q_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_out_data <= y_live;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
